/* design/ltcc_pkg.sv */
// Shared constants, ROM tables and types for the log time code converter.
package ltcc_pkg;

   localparam int MsWidth      = 40;
   localparam int CodeWidth    = 8;
   localparam int UsWidth      = 47;
   localparam int MsOutWidth   = 37;
   localparam int UsProdWidth  = 50;
   localparam int ReqDataWidth = 48;
   localparam int RspDataWidth = 96;

   localparam longint unsigned STEP_DIV  = 64'd100000;
   localparam longint unsigned US_PER_MS = 64'd1000;
   localparam logic [CodeWidth-1:0] CODE_MAX = 8'd253;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   // coarse seeds: 1.1^(16k-64) s in microseconds
   localparam logic [44:0] COARSE_ROM [16] = '{
      45'd2243,            45'd10307,          45'd47362,          45'd217629,
      45'd1000000,         45'd4594972,        45'd21113776,       45'd97017233,
      45'd445791568,       45'd2048400214,     45'd9412343651,     45'd43249464815,
      45'd198730122503,    45'd913159544478,   45'd4195943439113,  45'd19280246755010
   };

   // fine steps: 1.1^j scaled by 100000
   localparam logic [18:0] STEP_ROM [16] = '{
      19'd100000, 19'd110000, 19'd121000, 19'd133100,
      19'd146410, 19'd161051, 19'd177156, 19'd194871,
      19'd214358, 19'd235794, 19'd259374, 19'd285311,
      19'd313842, 19'd345227, 19'd379749, 19'd417724
   };

   typedef logic [UsWidth-1:0]    us_tab_type [256];
   typedef logic [MsOutWidth-1:0] ms_tab_type [256];

   // seed*step/100000 for every code, worked out at elaboration
   function automatic us_tab_type build_us_tab();
      us_tab_type      tab;
      longint unsigned prod;
      for (int c = 0; c < 256; c++) begin
         prod   = 64'(COARSE_ROM[c / 16]) * 64'(STEP_ROM[c % 16]);
         tab[c] = UsWidth'(prod / STEP_DIV);
      end
      return tab;
   endfunction

   function automatic ms_tab_type build_ms_tab();
      ms_tab_type      tab;
      longint unsigned prod;
      for (int c = 0; c < 256; c++) begin
         prod   = 64'(COARSE_ROM[c / 16]) * 64'(STEP_ROM[c % 16]);
         tab[c] = MsOutWidth'((prod / STEP_DIV) / US_PER_MS);
      end
      return tab;
   endfunction

   localparam us_tab_type US_TAB = build_us_tab();
   localparam ms_tab_type MS_TAB = build_ms_tab();

endpackage

/* design/ltcc_encoder.sv */
// Encoder: milliseconds to an 8-bit logarithmic code.
module ltcc_encoder
   import ltcc_pkg::*;
(
   input  logic [MsWidth-1:0]   time_ms,
   output logic [CodeWidth-1:0] code
);

   logic [UsProdWidth-1:0] us;
   logic [3:0]             seed_idx;
   logic [4:0]             step_idx;
   logic [8:0]             raw_code;

   always_comb begin
      us = UsProdWidth'(time_ms) * UsProdWidth'(US_PER_MS);

      // seeds rise monotonically, so counting the ones passed gives the row
      seed_idx = '0;
      for (int k = 1; k < 16; k++) begin
         if (us >= UsProdWidth'(COARSE_ROM[k])) begin
            seed_idx = seed_idx + 4'd1;
         end
      end

      step_idx = '0;
      for (int j = 0; j < 16; j++) begin
         if (us > UsProdWidth'(US_TAB[{seed_idx, 4'(j)}])) begin
            step_idx = step_idx + 5'd1;
         end
      end

      raw_code = {1'b0, seed_idx, 4'b0} + 9'(step_idx);

      if (time_ms == '0) begin
         code = '0;
      end else if (us < UsProdWidth'(COARSE_ROM[0])) begin
         code = 8'd1;
      end else if (raw_code > 9'(CODE_MAX)) begin
         code = CODE_MAX;
      end else begin
         code = raw_code[CodeWidth-1:0];
      end
   end

endmodule

/* design/ltcc_decoder.sv */
// Decoder: 8-bit logarithmic code to microseconds and milliseconds.
module ltcc_decoder
   import ltcc_pkg::*;
(
   input  logic [CodeWidth-1:0]  code,
   output logic [UsWidth-1:0]    time_us,
   output logic [MsOutWidth-1:0] time_ms
);

   always_comb begin
      if (code == '0) begin
         time_us = '0;
         time_ms = '0;
      end else begin
         time_us = US_TAB[code];
         time_ms = MS_TAB[code];
      end
   end

endmodule

/* design/log_time_code_converter.sv */
// A request passes an input register, then a result register, before its result is valid.
// Throughput: one request per cycle unless the result stalls; the encode and decode paths
// are ROM lookups, a constant multiply and 16-way compares between the two registers.
// With the result not taken, an empty input register takes one more request, then the input stalls.
// Reset (synchronous, active high) clears both valid flags; no clearing pass.
module log_time_code_converter
   import ltcc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,  // time_ms[39:0], code_in[47:40]
   input  logic                    req_tuser,  // operation
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata   // code_out[7:0], time_us[54:8],
                                               // time_ms_out[91:55], zero[95:92]
);

   logic                    in_valid_ff, in_valid_in;
   op_type                  in_op_ff;
   logic [MsWidth-1:0]      in_ms_ff;
   logic [CodeWidth-1:0]    in_code_ff;

   logic                    out_valid_ff, out_valid_in;
   logic [CodeWidth-1:0]    out_code_ff, out_code_in;
   logic [UsWidth-1:0]      out_us_ff, out_us_in;
   logic [MsOutWidth-1:0]   out_ms_ff, out_ms_in;

   logic                    out_load;
   logic                    in_load;
   logic [CodeWidth-1:0]    enc_code;
   logic [UsWidth-1:0]      dec_us;
   logic [MsOutWidth-1:0]   dec_ms;

   ltcc_encoder u_encoder (
      .time_ms (in_ms_ff),
      .code    (enc_code)
   );

   ltcc_decoder u_decoder (
      .code    (in_code_ff),
      .time_us (dec_us),
      .time_ms (dec_ms)
   );

   always_comb begin
      out_load     = !out_valid_ff || rsp_tready;
      req_tready   = !in_valid_ff || out_load;
      in_load      = req_tvalid && req_tready;
      in_valid_in  = in_load ? 1'b1 : (out_load ? 1'b0 : in_valid_ff);
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;

      if (in_op_ff == OP_DECODE) begin
         out_code_in = '0;
         out_us_in   = dec_us;
         out_ms_in   = dec_ms;
      end else begin
         out_code_in = enc_code;
         out_us_in   = '0;
         out_ms_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_op_ff   <= op_type'(req_tuser);
         in_ms_ff   <= req_tdata[MsWidth-1:0];
         in_code_ff <= req_tdata[MsWidth +: CodeWidth];
      end
      if (out_load && in_valid_ff) begin
         out_code_ff <= out_code_in;
         out_us_ff   <= out_us_in;
         out_ms_ff   <= out_ms_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_ms_ff, out_us_ff, out_code_ff};

   // encoded codes never pass the saturation limit
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_code_ff <= CODE_MAX)
      else $error("code_out above saturation limit");

   // a result carries either a code or a time, never both
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_code_ff == '0 || (out_us_ff == '0 && out_ms_ff == '0)))
      else $error("code and time both set in one result");

   // milliseconds are the truncated microseconds
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (UsProdWidth'(out_ms_ff) * UsProdWidth'(US_PER_MS) <= UsProdWidth'(out_us_ff))
                    && (UsProdWidth'(out_us_ff) < UsProdWidth'(out_ms_ff) * UsProdWidth'(US_PER_MS)
                                                  + UsProdWidth'(US_PER_MS)))
      else $error("time_ms_out inconsistent with time_us");

   // a held request in the input register is not dropped while the result stalls
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_load) |=> in_valid_ff && out_valid_ff)
      else $error("stalled request lost");

endmodule

/* sim/log_time_code_converter_tb.sv */
// Testbench for log_time_code_converter: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module log_time_code_converter_tb
   import ltcc_pkg::*;
();

   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned DirCount   = 22;
   localparam int unsigned HoldCycles = 90;

   typedef struct packed {
      op_type      op;
      logic [39:0] ms;
      logic [7:0]  code;
   } conv_request_type;

   typedef struct packed {
      logic [7:0]  code_out;
      logic [46:0] us;
      logic [36:0] ms_out;
   } conv_result_type;

   typedef struct packed {
      op_type      op;
      logic [39:0] ms;
      logic [7:0]  code;
      logic        known;
      logic [7:0]  code_out;
      logic [46:0] us;
      logic [36:0] ms_out;
   } dir_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;  // time_ms[39:0], code_in[47:40]
   logic                    req_tuser = 1'b0;  // operation
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;  // code_out[7:0], time_us[54:8], time_ms_out[91:55]

   // own copy of the seed and step tables
   longint unsigned seed_us_tab [16] = '{
      64'd2243,         64'd10307,         64'd47362,         64'd217629,
      64'd1000000,      64'd4594972,       64'd21113776,      64'd97017233,
      64'd445791568,    64'd2048400214,    64'd9412343651,    64'd43249464815,
      64'd198730122503, 64'd913159544478,  64'd4195943439113, 64'd19280246755010
   };
   longint unsigned step_scale_tab [16] = '{
      64'd100000, 64'd110000, 64'd121000, 64'd133100,
      64'd146410, 64'd161051, 64'd177156, 64'd194871,
      64'd214358, 64'd235794, 64'd259374, 64'd285311,
      64'd313842, 64'd345227, 64'd379749, 64'd417724
   };

   dir_row_type directed_tab [DirCount] = '{
      '{OP_ENCODE, 40'd0,             8'd0,   1'b1, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd1,             8'd0,   1'b1, 8'd1,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd2,             8'hAA,  1'b1, 8'd1,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd3,             8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd10,            8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd11,            8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd1000,          8'd0,   1'b1, 8'd64,  47'd0,       37'd0},
      '{OP_ENCODE, 40'd1001,          8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd19280246755,   8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd19280246756,   8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd80000000000,   8'd0,   1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'hFF_FFFF_FFFF,  8'hFF,  1'b1, 8'd253, 47'd0,       37'd0},
      '{OP_DECODE, 40'hFF_FFFF_FFFF,  8'd0,   1'b1, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'd0,             8'd1,   1'b1, 8'd0,   47'd2467,    37'd2},
      '{OP_DECODE, 40'h55_5555_5555,  8'd64,  1'b1, 8'd0,   47'd1000000, 37'd1000},
      '{OP_DECODE, 40'd0,             8'd15,  1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'd0,             8'd16,  1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'd0,             8'd128, 1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'd0,             8'd253, 1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'd0,             8'd254, 1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_DECODE, 40'hAA_AAAA_AAAA,  8'd255, 1'b0, 8'd0,   47'd0,       37'd0},
      '{OP_ENCODE, 40'd0,             8'h55,  1'b1, 8'd0,   47'd0,       37'd0}
   };

   conv_result_type pending_results [$];
   int unsigned     mismatches = 0;
   int unsigned     cycle_count = 0;
   bit              gaps_on = 1'b1;
   bit              hold_off_req = 1'b0;

   log_time_code_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned code_to_us(logic [7:0] code);
      if (code == 8'd0) return 64'd0;
      return (seed_us_tab[code[7:4]] * step_scale_tab[code[3:0]]) / 64'd100000;
   endfunction

   function automatic logic [7:0] ms_to_code(logic [39:0] ms);
      longint unsigned us;
      longint unsigned seed;
      longint unsigned code;
      int              k;
      int              j;
      if (ms == 40'd0) return 8'd0;
      us = 64'(ms) * 64'd1000;
      if (us < seed_us_tab[0]) return 8'd1;
      k = 15;
      for (int i = 1; i < 16; i++) begin
         if (us < seed_us_tab[i]) begin
            k = i - 1;
            break;
         end
      end
      seed = seed_us_tab[k];
      j = 0;
      // first step whose threshold is not below the time; may run past all 16
      while (j < 16 && us > (seed * step_scale_tab[j]) / 64'd100000) j++;
      code = 64'(16 * k + j);
      return (code > 64'd253) ? 8'd253 : code[7:0];
   endfunction

   function automatic conv_result_type convert_request(conv_request_type r);
      conv_result_type res;
      longint unsigned us;
      res = '0;
      if (r.op == OP_ENCODE) begin
         res.code_out = ms_to_code(r.ms);
      end else begin
         us         = code_to_us(r.code);
         res.us     = us[46:0];
         res.ms_out = 37'(us / 64'd1000);
      end
      return res;
   endfunction

   // drive one request and hold it until the block takes it
   task automatic send_request(conv_request_type r, conv_result_type res);
      req_tvalid <= 1'b1;
      req_tdata  <= {r.code, r.ms};
      req_tuser  <= r.op;
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(res);
   endtask

   task automatic sender_gap(int unsigned n);
      req_tvalid <= 1'b0;
      req_tdata  <= ReqDataWidth'({$urandom, $urandom});
      req_tuser  <= 1'($urandom);
      repeat (n) @(posedge clock);
   endtask

   function automatic conv_request_type random_request();
      conv_request_type r;
      longint unsigned  raw;
      longint unsigned  thr;
      int unsigned      sel;
      int unsigned      nbits;
      logic [7:0]       c;
      raw    = {$urandom, $urandom};
      r.ms   = raw[39:0];
      r.code = 8'($urandom);
      sel    = $urandom_range(0, 9);
      if (sel < 4) begin
         r.op = OP_DECODE;
      end else if (sel < 8) begin
         // land right on or next to a step threshold
         r.op = OP_ENCODE;
         c    = 8'($urandom_range(1, 255));
         thr  = code_to_us(c) / 64'd1000 + 64'($urandom_range(0, 2));
         if (thr != 0 && $urandom_range(0, 1) == 1) thr--;
         r.ms = thr[39:0];
      end else begin
         r.op  = OP_ENCODE;
         nbits = $urandom_range(0, 40);
         r.ms  = raw[39:0] & 40'((64'd1 << nbits) - 64'd1);
      end
      return r;
   endfunction

   task automatic send_random(int unsigned n);
      conv_request_type r;
      repeat (n) begin
         r = random_request();
         send_request(r, convert_request(r));
         if (gaps_on && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 7));
      end
   endtask

   task automatic note_mismatch(string field, longint unsigned exp_v, longint unsigned act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d (cycle %0d)",
                  field, exp_v, act_v, cycle_count);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      conv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result at cycle %0d", cycle_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[7:0] !== want.code_out)
               note_mismatch("code_out", want.code_out, rsp_tdata[7:0]);
            if (rsp_tdata[54:8] !== want.us)
               note_mismatch("time_us", want.us, rsp_tdata[54:8]);
            if (rsp_tdata[91:55] !== want.ms_out)
               note_mismatch("time_ms_out", want.ms_out, rsp_tdata[91:55]);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      conv_request_type r;
      conv_result_type  res;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DirCount; i++) begin
         r = '{directed_tab[i].op, directed_tab[i].ms, directed_tab[i].code};
         if (directed_tab[i].known)
            res = '{directed_tab[i].code_out, directed_tab[i].us, directed_tab[i].ms_out};
         else
            res = convert_request(r);
         send_request(r, res);
      end

      send_random(280);

      // long receiver stall while requests keep coming
      hold_off_req = 1'b1;
      send_random(30);

      // wait for the pipeline to drain completely
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      send_random(280);

      gaps_on = 1'b0;
      send_random(110);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
design/ltcc_pkg.sv
design/ltcc_encoder.sv
design/ltcc_decoder.sv
design/log_time_code_converter.sv
sim/log_time_code_converter_tb.sv
